@@ sv/bitset_store_with_range_any_top_assert.svh @@
// Assertion macros for the bit store block.
// Used by the top level through `include; needs no other file.
`ifndef BITSET_STORE_WITH_RANGE_ANY_TOP_ASSERT_SVH
`define BITSET_STORE_WITH_RANGE_ANY_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define BSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/bss_pkg.sv @@
// Shared types, constants and the word mask function of the bit store.
// No dependencies; used by bss_mem and the top level.
package bss_pkg;

    localparam int WORD_BITS    = 16;
    localparam int NUM_BITS_DEF = 1024;
    localparam int IDX_W        = 11;
    localparam int MODE_W       = 2;
    localparam int OFF_W        = 4;   // bit offset inside a word
    localparam int HI_W         = 5;   // exclusive upper offset, 0..16

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR = 2'd0,
        MODE_GET   = 2'd1,
        MODE_SET   = 2'd2,
        MODE_ANY   = 2'd3
    } t_mode;

    // Mask of offsets [lo, hi) in a word, most significant bit is offset 0
    function automatic t_word range_mask(input logic [OFF_W-1:0] lo,
                                         input logic [HI_W-1:0]  hi);
        t_word ones;
        ones = '1;
        return (ones >> lo) & ~(ones >> hi);
    endfunction

endpackage

@@ sv/bss_mem.sv @@
// Word memory of the bit store: one write port, one read port, registered read.
// Depends on bss_pkg for the word type.
module bss_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  bss_pkg::t_word       i_wr_data,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output bss_pkg::t_word       o_rd_data
);

    bss_pkg::t_word r_mem [DEPTH];
    bss_pkg::t_word r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, data valid the cycle after the address
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/bitset_store_with_range_any_top.sv @@
// Bit store of NUM_BITS bits in 16-bit words (MSB first) with get, set, clear
// and an "any bit set in [index, value)" range query. After reset, and for each
// clear item, a clearing pass writes zero to one word per cycle, all WORD_COUNT
// words, with the input not ready. A get or set goes through decode, a read and
// a check or write state (set is a read-modify-write of one word, no result).
// A range query reads one word per cycle through the single memory read port
// and checks it with the shared mask unit, stopping early if a one is found.
// Get and range errors and empty ranges answer from decode; a set out of range
// is dropped. One item is in work at a time, and a new item is taken only after
// the previous result has left the output register.
// Depends on bss_pkg, bss_mem and bitset_store_with_range_any_top_assert.svh.
`include "bitset_store_with_range_any_top_assert.svh"

module bitset_store_with_range_any_top #(
    parameter int NUM_BITS = bss_pkg::NUM_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [10:0] index, [21:11] value, [23:22] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] answer, [1] range_error, [7:2] zero
    output logic [0:0]  m_axis_tuser    // [0] result_kind
);

    localparam int WORD_COUNT = (NUM_BITS + bss_pkg::WORD_BITS - 1) / bss_pkg::WORD_BITS;
    localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int IDX_W      = bss_pkg::IDX_W;
    localparam int OFF_W      = bss_pkg::OFF_W;
    localparam int HI_W       = bss_pkg::HI_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_GET_RD,
        ST_GET_CHK,
        ST_SET_RD,
        ST_SET_WR,
        ST_ANY
    } t_state;

    t_state              r_state;
    bss_pkg::t_mode      r_mode;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_val;
    logic [AW-1:0]       r_clr_addr;
    logic [AW-1:0]       r_walk;
    logic [AW-1:0]       r_last_w;
    logic                r_iss_act;
    logic                r_iss_first;
    logic                r_chk_valid;
    logic                r_chk_first;
    logic                r_chk_last;
    logic                r_out_valid;
    logic                r_out_answer;
    logic                r_out_kind;
    logic                r_out_err;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    bss_pkg::t_word      wr_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    bss_pkg::t_word      rd_data;

    logic [AW-1:0]       idx_word;
    logic [OFF_W-1:0]    mask_lo;
    logic [HI_W-1:0]     mask_hi;
    bss_pkg::t_word      mask;
    logic                hit;
    logic                idx_oob;
    logic                any_oob;
    logic                s_accept;

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && !r_out_valid;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_err, r_out_answer};
    assign m_axis_tuser  = r_out_kind;

    // Address and bounds of the latched item
    assign idx_word = AW'(r_idx >> OFF_W);
    assign idx_oob  = 32'(r_idx) >= 32'(NUM_BITS);
    assign any_oob  = (32'(r_idx) > 32'(NUM_BITS)) || (32'(r_val) > 32'(NUM_BITS));

    // Shared mask unit: single bit for get/set, edge-aware range for a walk
    always_comb begin
        if (r_state == ST_ANY) begin
            mask_lo = r_chk_first ? r_idx[OFF_W-1:0] : '0;
            if (r_chk_last && (r_val[OFF_W-1:0] != '0)) begin
                mask_hi = {1'b0, r_val[OFF_W-1:0]};
            end else begin
                mask_hi = HI_W'(bss_pkg::WORD_BITS);
            end
        end else begin
            mask_lo = r_idx[OFF_W-1:0];
            mask_hi = {1'b0, r_idx[OFF_W-1:0]} + HI_W'(1);
        end
    end

    assign mask = bss_pkg::range_mask(mask_lo, mask_hi);
    assign hit  = |(rd_data & mask);

    // Memory port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = idx_word;
        wr_en   = 1'b0;
        wr_addr = idx_word;
        wr_data = '0;
        unique case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_addr;
            end
            ST_GET_RD, ST_SET_RD: begin
                rd_en = 1'b1;
            end
            ST_SET_WR: begin
                wr_en   = 1'b1;
                wr_data = (r_val == IDX_W'(1)) ? (rd_data | mask) : (rd_data & ~mask);
            end
            ST_ANY: begin
                rd_en   = r_iss_act;
                rd_addr = r_walk;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    bss_mem #(
        .DEPTH (WORD_COUNT),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_iss_act   <= 1'b0;
            r_iss_first <= 1'b0;
            r_chk_valid <= 1'b0;
            r_chk_first <= 1'b0;
            r_chk_last  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // a waiting result holds the sequencer in idle
            if (m_axis_tready && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(WORD_COUNT - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_accept) begin
                        r_mode  <= bss_pkg::t_mode'(s_axis_tuser);
                        r_idx   <= s_axis_tdata[IDX_W-1:0];
                        r_val   <= s_axis_tdata[2*IDX_W-1:IDX_W];
                        r_state <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    unique case (r_mode)
                        bss_pkg::MODE_CLEAR: begin
                            r_clr_addr <= '0;
                            r_state    <= ST_CLEAR;
                        end
                        bss_pkg::MODE_GET: begin
                            if (idx_oob) begin
                                r_out_valid  <= 1'b1;
                                r_out_answer <= 1'b0;
                                r_out_kind   <= 1'b0;
                                r_out_err    <= 1'b1;
                                r_state      <= ST_IDLE;
                            end else begin
                                r_state <= ST_GET_RD;
                            end
                        end
                        bss_pkg::MODE_SET: begin
                            r_state <= idx_oob ? ST_IDLE : ST_SET_RD;
                        end
                        bss_pkg::MODE_ANY: begin
                            if (any_oob || (r_idx >= r_val)) begin
                                r_out_valid  <= 1'b1;
                                r_out_answer <= 1'b0;
                                r_out_kind   <= 1'b1;
                                r_out_err    <= any_oob;
                                r_state      <= ST_IDLE;
                            end else begin
                                r_walk      <= idx_word;
                                r_last_w    <= AW'((r_val - IDX_W'(1)) >> OFF_W);
                                r_iss_act   <= 1'b1;
                                r_iss_first <= 1'b1;
                                r_chk_valid <= 1'b0;
                                r_state     <= ST_ANY;
                            end
                        end
                        default: begin
                            r_state <= ST_IDLE;
                        end
                    endcase
                end
                ST_GET_RD: begin
                    r_state <= ST_GET_CHK;
                end
                ST_GET_CHK: begin
                    r_out_valid  <= 1'b1;
                    r_out_answer <= hit;
                    r_out_kind   <= 1'b0;
                    r_out_err    <= 1'b0;
                    r_state      <= ST_IDLE;
                end
                ST_SET_RD: begin
                    r_state <= ST_SET_WR;
                end
                ST_SET_WR: begin
                    r_state <= ST_IDLE;
                end
                ST_ANY: begin
                    if (r_chk_valid && (hit || r_chk_last)) begin
                        // check side: stop on a hit or after the right edge word
                        r_iss_act    <= 1'b0;
                        r_chk_valid  <= 1'b0;
                        r_out_valid  <= 1'b1;
                        r_out_answer <= hit;
                        r_out_kind   <= 1'b1;
                        r_out_err    <= 1'b0;
                        r_state      <= ST_IDLE;
                    end else if (r_iss_act) begin
                        // issue side: one word address per cycle
                        r_walk      <= r_walk + AW'(1);
                        r_iss_first <= 1'b0;
                        r_chk_valid <= 1'b1;
                        r_chk_first <= r_iss_first;
                        r_chk_last  <= (r_walk == r_last_w);
                        if (r_walk == r_last_w) begin
                            r_iss_act <= 1'b0;
                        end
                    end else begin
                        r_chk_valid <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Checks
    `BSS_ASSERT_NOW(a_clear_writes_zero, i_clk, i_rst_n,
        r_state == ST_CLEAR, wr_en && (wr_data == '0), "clearing pass wrote nonzero")
    `BSS_ASSERT_NOW(a_walk_in_range, i_clk, i_rst_n,
        (r_state == ST_ANY) && r_iss_act, r_walk <= r_last_w, "range walk passed last word")
    `BSS_ASSERT_NOW(a_error_answer_zero, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tdata[1], !m_axis_tdata[0], "range error with answer one")

endmodule

@@ sim/tb_top.sv @@
// Testbench for the bit store with get, set, clear and range "any" query.
// Uses bss_pkg and bitset_store_with_range_any_top; directed and random items
// are checked against a local model of the store under varied stream idling.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_BITS = bss_pkg::NUM_BITS_DEF;
    localparam int STORE_WORDS = (STORE_BITS + bss_pkg::WORD_BITS - 1) / bss_pkg::WORD_BITS;

    typedef struct packed {
        logic answer;
        logic range_error;
        logic result_kind;
    } t_store_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // [10:0] index, [21:11] value, [23:22] zero
    logic [1:0]  s_axis_tuser;   // [1:0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [0] answer, [1] range_error, [7:2] zero
    logic [0:0]  m_axis_tuser;   // [0] result_kind

    // Local copy of the store and the answers still owed by the block
    bss_pkg::t_word model_words [0:STORE_WORDS-1];
    t_store_answer  pending_answers[$];
    int unsigned    mismatch_count;
    int unsigned    send_idle_pct;
    int unsigned    recv_stall_pct;

    bitset_store_with_range_any_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #4ms;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Bit b lives in word b/16, offset 0 being the word's top bit
    function automatic logic stored_bit(input int b);
        return model_words[b / bss_pkg::WORD_BITS]
                          [bss_pkg::WORD_BITS - 1 - (b % bss_pkg::WORD_BITS)];
    endfunction

    function automatic logic range_has_one(input int left, input int right);
        for (int b = left; b < right; b++) begin
            if (stored_bit(b)) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Update the store model for one accepted item and queue its answer, if any
    task automatic apply_store_op(input bss_pkg::t_mode m, input logic [10:0] bit_index,
                                  input logic [10:0] bit_value);
        t_store_answer ans;
        int idx;
        int val;
        idx = int'(bit_index);
        val = int'(bit_value);
        ans = '0;
        case (m)
            bss_pkg::MODE_CLEAR: begin
                foreach (model_words[w]) model_words[w] = '0;
            end
            bss_pkg::MODE_GET: begin
                if (idx >= STORE_BITS) begin
                    ans.range_error = 1'b1;
                end else begin
                    ans.answer = stored_bit(idx);
                end
                pending_answers.push_back(ans);
            end
            bss_pkg::MODE_SET: begin
                // a value other than one clears the bit
                if (idx < STORE_BITS)
                    model_words[idx / bss_pkg::WORD_BITS]
                               [bss_pkg::WORD_BITS - 1 - (idx % bss_pkg::WORD_BITS)] =
                        (val == 1);
            end
            default: begin
                ans.result_kind = 1'b1;
                if (idx > STORE_BITS || val > STORE_BITS) begin
                    ans.range_error = 1'b1;
                end else begin
                    ans.answer = range_has_one(idx, val);
                end
                pending_answers.push_back(ans);
            end
        endcase
    endtask

    // Offer one item after a random idle stretch; tvalid stays high on return
    task automatic send_item(input bss_pkg::t_mode m, input logic [10:0] bit_index,
                             input logic [10:0] bit_value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, bit_value, bit_index};
        s_axis_tuser  <= m;
        do @(posedge i_clk); while (!s_axis_tready);
        apply_store_op(m, bit_index, bit_value);
    endtask

    task automatic check_answer();
        t_store_answer got;
        t_store_answer want;
        got.answer      = m_axis_tdata[0];
        got.range_error = m_axis_tdata[1];
        got.result_kind = m_axis_tuser[0];
        if (pending_answers.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: %b", got));
            return;
        end
        want = pending_answers.pop_front();
        if (got.answer !== want.answer)
            report_mismatch($sformatf("answer %b, expected %b", got.answer, want.answer));
        if (got.range_error !== want.range_error)
            report_mismatch($sformatf("range_error %b, expected %b",
                                      got.range_error, want.range_error));
        if (got.result_kind !== want.result_kind)
            report_mismatch($sformatf("result_kind %b, expected %b",
                                      got.result_kind, want.result_kind));
    endtask

    // Result side: check on each accepted item, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_answer();
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Single-bit reads at both ends of the store and past it
    task automatic test_get_edges();
        send_item(bss_pkg::MODE_GET, 11'd0, 11'd0);
        send_item(bss_pkg::MODE_GET, 11'd1023, 11'd2047);
        send_item(bss_pkg::MODE_GET, 11'd1024, 11'd0);
        send_item(bss_pkg::MODE_GET, 11'd2047, 11'd0);
    endtask

    // Writes at word edges, clearing by a value other than one, ignored write
    task automatic test_set_and_get();
        send_item(bss_pkg::MODE_SET, 11'd0, 11'd1);
        send_item(bss_pkg::MODE_SET, 11'd1023, 11'd1);
        send_item(bss_pkg::MODE_SET, 11'd15, 11'd1);
        send_item(bss_pkg::MODE_SET, 11'd16, 11'd1);
        send_item(bss_pkg::MODE_GET, 11'd0, 11'd0);
        send_item(bss_pkg::MODE_GET, 11'd1023, 11'd0);
        send_item(bss_pkg::MODE_GET, 11'd16, 11'd0);
        send_item(bss_pkg::MODE_SET, 11'd15, 11'd2047);
        send_item(bss_pkg::MODE_GET, 11'd15, 11'd0);
        send_item(bss_pkg::MODE_SET, 11'd1024, 11'd1);
    endtask

    // Range queries: edge words, empty ranges, bounds past the store
    task automatic test_range_query();
        send_item(bss_pkg::MODE_ANY, 11'd0, 11'd1024);
        send_item(bss_pkg::MODE_ANY, 11'd1, 11'd16);
        send_item(bss_pkg::MODE_ANY, 11'd1, 11'd17);
        send_item(bss_pkg::MODE_ANY, 11'd17, 11'd1023);
        send_item(bss_pkg::MODE_ANY, 11'd17, 11'd1024);
        send_item(bss_pkg::MODE_ANY, 11'd5, 11'd5);
        send_item(bss_pkg::MODE_ANY, 11'd10, 11'd3);
        send_item(bss_pkg::MODE_ANY, 11'd1024, 11'd1024);
        send_item(bss_pkg::MODE_ANY, 11'd0, 11'd1025);
        send_item(bss_pkg::MODE_ANY, 11'd2047, 11'd2047);
    endtask

    // Clear ignores its index and value fields and empties the whole store
    task automatic test_clear();
        send_item(bss_pkg::MODE_CLEAR, 11'd2047, 11'd2047);
        send_item(bss_pkg::MODE_ANY, 11'd0, 11'd1024);
    endtask

    task automatic send_random_item();
        int unsigned pick;
        int unsigned left;
        int unsigned right;
        logic [10:0] bit_index;
        logic [10:0] bit_value;
        pick = $urandom_range(99);
        bit_index = ($urandom_range(99) < 93) ? 11'($urandom_range(STORE_BITS - 1))
                                             : 11'($urandom_range(2047, STORE_BITS));
        if (pick < 2) begin
            send_item(bss_pkg::MODE_CLEAR, 11'($urandom_range(2047)),
                      11'($urandom_range(2047)));
        end else if (pick < 42) begin
            pick = $urandom_range(99);
            bit_value = (pick < 80) ? 11'd1 : (pick < 95) ? 11'd0
                                                           : 11'($urandom_range(2047));
            send_item(bss_pkg::MODE_SET, bit_index, bit_value);
        end else if (pick < 62) begin
            send_item(bss_pkg::MODE_GET, bit_index, 11'($urandom_range(2047)));
        end else begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                // at least one bound past the store
                left  = $urandom_range(2047);
                right = $urandom_range(2047, STORE_BITS + 1);
                if ($urandom_range(1)) send_item(bss_pkg::MODE_ANY, 11'(right), 11'(left));
                else send_item(bss_pkg::MODE_ANY, 11'(left), 11'(right));
            end else if (pick < 10) begin
                right = $urandom_range(STORE_BITS);
                left  = $urandom_range(STORE_BITS, right);
                send_item(bss_pkg::MODE_ANY, 11'(left), 11'(right));
            end else if (pick < 15) begin
                left = $urandom_range(STORE_BITS - 1);
                send_item(bss_pkg::MODE_ANY, 11'(left), 11'(STORE_BITS));
            end else begin
                left  = $urandom_range(STORE_BITS - 1);
                right = left + $urandom_range(40);
                if (right > STORE_BITS) right = STORE_BITS;
                send_item(bss_pkg::MODE_ANY, 11'(left), 11'(right));
            end
        end
    endtask

    task automatic test_random_traffic(input int unsigned n_items,
                                       input int unsigned send_idle,
                                       input int unsigned recv_stall);
        send_idle_pct  = send_idle;
        recv_stall_pct = recv_stall;
        repeat (n_items) send_random_item();
    endtask

    initial begin
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        foreach (model_words[w]) model_words[w] = '0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= bss_pkg::MODE_CLEAR;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_get_edges();
        test_set_and_get();
        test_range_query();
        test_clear();
        test_random_traffic(320, 0, 0);
        test_random_traffic(310, 86, 0);
        test_random_traffic(310, 0, 86);
        test_random_traffic(310, 17, 17);

        // drain the outstanding answers
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
